// File: design/flag_bitmap_allocator_unit_defines.svh
// assertion macros for the flag bitmap allocator
`ifndef FLAG_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FLAG_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication on clk, disabled during reset
`define FBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fba check failed");

// next-cycle implication on clk, disabled during reset
`define FBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fba check failed");

`endif

// File: design/fba_pkg.sv
package fba_pkg;

  localparam int FIRST_FLAG = 24;
  localparam int LAST_FLAG  = 63;
  localparam int NUM_FLAGS  = LAST_FLAG - FIRST_FLAG + 1;
  localparam int IDX_W      = $clog2(NUM_FLAGS);
  localparam int NUM_W      = 7;
  localparam int FLAG_W     = 6;
  localparam int STATUS_W   = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK           = 3'd0;
  localparam status_t ST_BADPARAM     = 3'd1;
  localparam status_t ST_RESERVED     = 3'd2;
  localparam status_t ST_ALREADY_FREE = 3'd3;
  localparam status_t ST_NONE_LEFT    = 3'd4;

  typedef struct packed {
    logic alloc;
    logic release_sel;
  } cell_cmd_t;

endpackage

// File: design/fba_cell.sv
module fba_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  fba_pkg::cell_cmd_t cmd,
  input  logic              sel,
  input  logic              free_seen_in,
  output logic              free_seen_out,
  output logic              grant,
  output logic              used
);
  import fba_pkg::*;

  logic used_r;
  logic used_nxt;

  assign grant         = cmd.alloc & ~free_seen_in & ~used_r;
  assign free_seen_out = free_seen_in | ~used_r;
  assign used          = used_r;

  always_comb begin
    used_nxt = used_r;
    if (grant) begin
      used_nxt = 1'b1;
    end else if (cmd.release_sel && sel) begin
      used_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

endmodule

// File: design/fba_chain.sv
module fba_chain (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fba_pkg::cell_cmd_t             cmd,
  input  logic [fba_pkg::NUM_FLAGS-1:0]  sel,
  output logic [fba_pkg::NUM_FLAGS-1:0]  grant,
  output logic [fba_pkg::NUM_FLAGS-1:0]  used,
  output logic                           any_free,
  output logic [fba_pkg::FLAG_W-1:0]     grant_flag
);
  import fba_pkg::*;

  logic [NUM_FLAGS:0]  free_seen;
  logic [IDX_W-1:0]    grant_idx;

  assign free_seen[0] = 1'b0;

  for (genvar g = 0; g < NUM_FLAGS; g++) begin : g_cell
    fba_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .sel          (sel[g]),
      .free_seen_in (free_seen[g]),
      .free_seen_out(free_seen[g+1]),
      .grant        (grant[g]),
      .used         (used[g])
    );
  end

  assign any_free = free_seen[NUM_FLAGS];

  // one-hot grant to index
  always_comb begin
    grant_idx = '0;
    for (int i = 0; i < NUM_FLAGS; i++) begin
      if (grant[i]) begin
        grant_idx = grant_idx | IDX_W'(i);
      end
    end
  end

  assign grant_flag = FLAG_W'(FIRST_FLAG) + FLAG_W'(grant_idx);

endmodule

// File: design/flag_bitmap_allocator_unit.sv
// flag bitmap allocator: hands out flag numbers 24 to 63, lowest free first
// input channel in_valid/in_stall carries in_func (0 allocate, 1 release)
// and in_flag_number (release target, ignored for allocate)
// result channel out_valid/out_stall carries out_status and
// out_allocated_flag, exactly one result per accepted request
// the result is registered and shows in the cycle after the input transfer
// throughput: one request per cycle while the output is not stalled, set by
// the single pass of the find-first-free carry through the row of 40 flag cells
// each cell holds one in-use bit and passes a "free seen" carry upward
// the output register holds a result while out_stall is high; input is
// stalled only while that register is full and stalled, so a transfer on
// the output frees room for a new request in the same cycle
// reset (synchronous, rst_n low) marks every flag free and empties the
// output register; no clearing pass is needed
`include "flag_bitmap_allocator_unit_defines.svh"

module flag_bitmap_allocator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [fba_pkg::NUM_W-1:0]     in_flag_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fba_pkg::STATUS_W-1:0]  out_status,
  output logic [fba_pkg::FLAG_W-1:0]    out_allocated_flag
);
  import fba_pkg::*;

  logic                  fire;
  logic                  alloc_fire;
  logic                  in_range;
  logic [NUM_W-1:0]      rel_off;
  logic [NUM_FLAGS-1:0]  sel;
  logic [NUM_FLAGS-1:0]  grant;
  logic [NUM_FLAGS-1:0]  used;
  logic                  any_free;
  logic [FLAG_W-1:0]     grant_flag;
  cell_cmd_t             cmd;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [FLAG_W-1:0]     flag_r;
  logic [FLAG_W-1:0]     flag_nxt;

  assign in_stall   = out_valid_r & out_stall;
  assign fire       = in_valid & ~in_stall;
  assign alloc_fire = fire & ~in_func;

  assign in_range = (in_flag_number >= NUM_W'(FIRST_FLAG)) &&
                    (in_flag_number <= NUM_W'(LAST_FLAG));
  assign rel_off  = in_flag_number - NUM_W'(FIRST_FLAG);

  for (genvar g = 0; g < NUM_FLAGS; g++) begin : g_sel
    assign sel[g] = in_range && (rel_off == NUM_W'(g));
  end

  assign cmd.alloc       = alloc_fire;
  assign cmd.release_sel = fire & in_func & in_range;

  fba_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sel       (sel),
    .grant     (grant),
    .used      (used),
    .any_free  (any_free),
    .grant_flag(grant_flag)
  );

  always_comb begin
    status_nxt = status_r;
    flag_nxt   = flag_r;
    if (fire) begin
      flag_nxt = '0;
      priority if (!in_func) begin
        if (any_free) begin
          status_nxt = ST_OK;
          flag_nxt   = grant_flag;
        end else begin
          status_nxt = ST_NONE_LEFT;
        end
      end else if (in_flag_number < NUM_W'(FIRST_FLAG)) begin
        status_nxt = ST_RESERVED;
      end else if (in_flag_number > NUM_W'(LAST_FLAG)) begin
        status_nxt = ST_BADPARAM;
      end else if (|(sel & used)) begin
        status_nxt = ST_OK;
      end else begin
        status_nxt = ST_ALREADY_FREE;
      end
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    flag_r   <= flag_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_allocated_flag = flag_r;

  `FBA_ASSERT_NOW(a_grant_onehot, 1'b1, $onehot0(grant))
  `FBA_ASSERT_NEXT(a_alloc_status, alloc_fire, (out_status == ST_OK) || (out_status == ST_NONE_LEFT))
  `FBA_ASSERT_NEXT(a_alloc_flag, alloc_fire && any_free, out_allocated_flag >= FLAG_W'(FIRST_FLAG))
  `FBA_ASSERT_NOW(a_flag_zero, out_valid_r && (out_status != ST_OK), out_allocated_flag == '0)

endmodule

// File: verif/fba_tb_pkg.sv
package fba_tb_pkg;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } request_t;

  typedef struct packed {
    logic [fba_pkg::STATUS_W-1:0] status;
    logic [fba_pkg::FLAG_W-1:0]   flag;
  } flag_result_t;

endpackage

// File: verif/fba_result_checker.sv
module fba_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_func,
  input  logic [fba_pkg::NUM_W-1:0]    in_flag_number,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [fba_pkg::STATUS_W-1:0] out_status,
  input  logic [fba_pkg::FLAG_W-1:0]   out_allocated_flag,
  output int                           fail_count,
  output int                           pending_count,
  output int                           checked_count,
  output int                           none_left_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fba_pkg::*;
  import fba_tb_pkg::*;

  logic [NUM_FLAGS-1:0] flags_in_use;
  flag_result_t         expected_q[$];
  int                   mismatches;
  int                   checked;
  int                   none_left;

  function automatic flag_result_t predict_request(input logic func,
                                                   input logic [NUM_W-1:0] num);
    flag_result_t r;
    int           idx;
    r.status = ST_NONE_LEFT;
    r.flag   = '0;
    if (func == REQ_ALLOC) begin
      for (idx = 0; idx < NUM_FLAGS; idx++) begin
        if (!flags_in_use[idx]) begin
          flags_in_use[idx] = 1'b1;
          r.flag   = FLAG_W'(FIRST_FLAG + idx);
          r.status = ST_OK;
          break;
        end
      end
    end else if (num < FIRST_FLAG) begin
      r.status = ST_RESERVED;
    end else if (num > LAST_FLAG) begin
      r.status = ST_BADPARAM;
    end else begin
      idx = int'(num) - FIRST_FLAG;
      if (!flags_in_use[idx]) begin
        r.status = ST_ALREADY_FREE;
      end else begin
        flags_in_use[idx] = 1'b0;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  initial begin
    flags_in_use    = '0;
    mismatches      = 0;
    checked         = 0;
    none_left       = 0;
    fail_count      = 0;
    pending_count   = 0;
    checked_count   = 0;
    none_left_count = 0;
  end

  always @(posedge clk) begin
    flag_result_t exp_res;
    if (!rst_n) begin
      flags_in_use = '0;
      expected_q.delete();
    end else begin
      // result side first: a result in this cycle belongs to an older request
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: status %0d flag %0d",
                     $realtime, out_status, out_allocated_flag);
        end else begin
          exp_res = expected_q.pop_front();
          checked++;
          if (exp_res.status == ST_NONE_LEFT)
            none_left++;
          if (out_status !== exp_res.status || out_allocated_flag !== exp_res.flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, flag exp %0d got %0d",
                       $realtime, exp_res.status, out_status, exp_res.flag,
                       out_allocated_flag);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_request(in_func, in_flag_number));
    end
    fail_count      <= mismatches;
    pending_count   <= expected_q.size();
    checked_count   <= checked;
    none_left_count <= none_left;
  end

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fba_pkg::*;
  import fba_tb_pkg::*;

  localparam int BLOCKS        = 18;
  localparam int BLOCK_ITEMS   = 102;
  localparam int HOLD_CYCLES   = 150;
  localparam int WATCHDOG_MAX  = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_func;
  logic [NUM_W-1:0]    in_flag_number;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [FLAG_W-1:0]   out_allocated_flag;

  int fail_count;
  int pending_count;
  int checked_count;
  int none_left_count;
  int sent_count;
  int quiet_cycles;
  bit idle_on;
  bit hold_req;

  flag_bitmap_allocator_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_flag_number     (in_flag_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_allocated_flag (out_allocated_flag)
  );

  fba_result_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_flag_number     (in_flag_number),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_allocated_flag (out_allocated_flag),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .checked_count      (checked_count),
    .none_left_count    (none_left_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_req(input request_t req, input logic [NUM_W-1:0] num);
    in_valid       <= 1'b1;
    in_func        <= req;
    in_flag_number <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random(input int alloc_pct);
    int pick;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      send_req(REQ_ALLOC, NUM_W'($urandom_range(0, 127)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_req(REQ_RELEASE, NUM_W'($urandom_range(0, FIRST_FLAG - 1)));
      else if (pick < 20)
        send_req(REQ_RELEASE, NUM_W'($urandom_range(LAST_FLAG + 1, 127)));
      else
        send_req(REQ_RELEASE, NUM_W'($urandom_range(FIRST_FLAG, LAST_FLAG)));
    end
  endtask

  // wait until every outstanding request has its result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("** flag_bitmap_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int alloc_pct_list[6];
    int blk;
    int n;
    alloc_pct_list = '{95, 85, 60, 35, 10, 75};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = REQ_ALLOC;
    in_flag_number = '0;
    sent_count     = 0;
    quiet_cycles   = 0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reserved, out of range and free-flag releases on an empty map
    send_req(REQ_RELEASE, 7'd0);
    send_req(REQ_RELEASE, 7'd23);
    send_req(REQ_RELEASE, 7'd24);
    send_req(REQ_RELEASE, 7'd63);
    send_req(REQ_RELEASE, 7'd64);
    send_req(REQ_RELEASE, 7'd127);
    send_req(REQ_RELEASE, 7'd85);
    send_req(REQ_RELEASE, 7'd42);
    // grant, release, re-grant of the lowest flag
    send_req(REQ_ALLOC, 7'd127);
    send_req(REQ_ALLOC, 7'd0);
    send_req(REQ_RELEASE, 7'd24);
    send_req(REQ_RELEASE, 7'd24);
    send_req(REQ_ALLOC, 7'd85);
    send_req(REQ_RELEASE, 7'd25);
    send_req(REQ_RELEASE, 7'd24);
    send_req(REQ_ALLOC, 7'd42);
    drain_results();

    for (blk = 0; blk < BLOCKS; blk++) begin
      idle_on = (blk % 4 != 2) && (blk < BLOCKS - 3);
      if (blk == 3)
        hold_req = 1'b1;
      if (blk == 8)
        drain_results();
      for (n = 0; n < BLOCK_ITEMS; n++)
        send_random(alloc_pct_list[blk % 6]);
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("run covered %0d requests across fill and drain phases with stalls on both sides",
             sent_count);
    $display("%0d results checked, %0d of them allocations with no flag left",
             checked_count, none_left_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** flag_bitmap_allocator_unit: PASSED **");
    end else begin
      $display("** flag_bitmap_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
